// ===== src/ssd_pkg.sv =====
// Shared constants, codes and controller/datapath types for the stereo SAD depth search.
package ssd_pkg;

   localparam int MAX_WIDTH   = 512;
   localparam int MAX_HEIGHT  = 512;
   localparam int MAX_RADIUS  = 7;
   localparam int COL_W       = $clog2(MAX_WIDTH);
   localparam int ROW_W       = $clog2(MAX_HEIGHT);
   localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int DIM_W       = 10;
   localparam int BLK_W       = 4;
   localparam int RAD_W       = 3;
   localparam int PIX_W       = 8;
   localparam int SUM_W       = 16;
   localparam int DEPTH_W     = 32;
   localparam int DISP_W      = 9;
   localparam int IDX_W       = 3;
   localparam int CSR_DATA_W  = 32;
   localparam int DIV_CNT_W   = $clog2(DEPTH_W);

   typedef enum logic [0:0] {
      OP_LOAD  = 1'b0,
      OP_QUERY = 1'b1
   } opcode_type;

   typedef enum logic [1:0] {
      STAT_VALID   = 2'd0,
      STAT_BORDER  = 2'd1,
      STAT_NOMATCH = 2'd2,
      STAT_ZERO    = 2'd3
   } status_type;

   typedef enum logic [IDX_W-1:0] {
      REG_FRAME_WIDTH  = 3'd0,
      REG_FRAME_HEIGHT = 3'd1,
      REG_BLOCK_SIZE   = 3'd2,
      REG_THRESHOLD    = 3'd3,
      REG_DEPTH_SCALE  = 3'd4
   } reg_index_type;

   typedef struct packed {
      logic load_wr;
      logic latch;
      logic check;
      logic scan_en;
      logic eval;
      logic div_en;
      logic publish;
   } ssd_cmd_type;

   typedef struct packed {
      logic border;
      logic gen_last;
      logic eval_valid;
      logic div_last;
      logic out_free;
   } ssd_sts_type;

endpackage

// ===== src/ssd_channels.sv =====
// Channel interfaces: query/load requests, results and register writes.
interface ssd_req_if import ssd_pkg::*; ;
   logic               valid;
   logic               ready;
   logic               opcode;
   logic [COL_W-1:0]   col;
   logic [ROW_W-1:0]   row;
   logic [PIX_W-1:0]   left_pixel;
   logic [PIX_W-1:0]   right_pixel;
   modport source (output valid, opcode, col, row, left_pixel, right_pixel, input ready);
   modport sink (input valid, opcode, col, row, left_pixel, right_pixel, output ready);
endinterface

interface ssd_rsp_if import ssd_pkg::*; ;
   logic               valid;
   logic               ready;
   logic [DEPTH_W-1:0] depth;
   logic [DISP_W-1:0]  disparity;
   logic [SUM_W-1:0]   best_sum;
   logic [1:0]         status;
   modport source (output valid, depth, disparity, best_sum, status, input ready);
   modport sink (input valid, depth, disparity, best_sum, status, output ready);
endinterface

interface ssd_csr_if import ssd_pkg::*; ;
   logic                  valid;
   logic                  ready;
   logic [IDX_W-1:0]      index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== src/ssd_ctrl.sv =====
// Sequencer for load, border check, window scan, divide and result hand-off.
module ssd_ctrl import ssd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_opcode,
   output logic        req_ready,
   input  ssd_sts_type sts,
   output ssd_cmd_type cmd
);

   typedef enum logic [6:0] {
      S_IDLE   = 7'b0000001,
      S_CHECK  = 7'b0000010,
      S_SCAN   = 7'b0000100,
      S_DRAIN  = 7'b0001000,
      S_EVAL   = 7'b0010000,
      S_DIVIDE = 7'b0100000,
      S_FINISH = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_opcode == OP_QUERY) begin
                  cmd.latch = 1'b1;
                  state_in  = S_CHECK;
               end else begin
                  cmd.load_wr = 1'b1;
               end
            end
         end
         S_CHECK: begin
            cmd.check = 1'b1;
            state_in  = sts.border ? S_FINISH : S_SCAN;
         end
         S_SCAN: begin
            cmd.scan_en = 1'b1;
            if (sts.gen_last) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            state_in = S_EVAL;
         end
         S_EVAL: begin
            cmd.eval = 1'b1;
            state_in = sts.eval_valid ? S_DIVIDE : S_FINISH;
         end
         S_DIVIDE: begin
            cmd.div_en = 1'b1;
            if (sts.div_last) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (sts.out_free) begin
               cmd.publish = 1'b1;
               state_in    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

// ===== src/ssd_datapath.sv =====
// Frame stores, window address walk, SAD accumulate, divider and result register.
module ssd_datapath import ssd_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  ssd_cmd_type           cmd,
   output ssd_sts_type           sts,
   input  logic [COL_W-1:0]      req_col,
   input  logic [ROW_W-1:0]      req_row,
   input  logic [PIX_W-1:0]      req_left_pixel,
   input  logic [PIX_W-1:0]      req_right_pixel,
   input  logic                  csr_valid,
   input  logic [IDX_W-1:0]      csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [DEPTH_W-1:0]    rsp_depth,
   output logic [DISP_W-1:0]     rsp_disparity,
   output logic [SUM_W-1:0]      rsp_best_sum,
   output logic [1:0]            rsp_status
);

   logic [PIX_W-1:0] left_mem  [STORE_DEPTH];
   logic [PIX_W-1:0] right_mem [STORE_DEPTH];

   logic [DIM_W-1:0]   fw_ff, fh_ff;
   logic [BLK_W-1:0]   blk_ff;
   logic [SUM_W-1:0]   thr_ff;
   logic [DEPTH_W-1:0] scale_ff;

   logic [COL_W-1:0]   x_ff, cen_ff, cen1_ff, pos_ff;
   logic [ROW_W-1:0]   y_ff;
   logic [BLK_W-1:0]   dx_ff, dy_ff;
   logic               v1_ff, last1_ff, first_ff;
   logic [PIX_W-1:0]   rd_l_ff, rd_r_ff;
   logic [SUM_W-1:0]   sum_ff, best_ff;
   logic [DISP_W-1:0]  disp_ff;
   logic [1:0]         stat_ff;
   logic [DEPTH_W-1:0] q_ff;
   logic [DISP_W-1:0]  rem_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;

   logic [DIM_W-1:0]   w_eff, h_eff;
   logic [RAD_W-1:0]   rad;
   logic [BLK_W-1:0]   span;
   logic [DIM_W:0]     x_e, y_e, r_e;
   logic               win_last;
   logic [ROW_W-1:0]   rd_row;
   logic [COL_W-1:0]   rd_col_l, rd_col_r;
   logic [PIX_W-1:0]   ad;
   logic [SUM_W-1:0]   cand;
   logic [DISP_W-1:0]  disp_w;
   logic [1:0]         eval_stat;
   logic [DISP_W:0]    trial, tdiff;
   logic               ge;

   // Effective geometry: clamp frame size, radius from block size.
   assign w_eff = (fw_ff == '0) ? DIM_W'(1) :
                  (fw_ff > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : fw_ff;
   assign h_eff = (fh_ff == '0) ? DIM_W'(1) :
                  (fh_ff > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : fh_ff;
   assign rad   = (blk_ff[BLK_W-1:1] > RAD_W'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS)
                                                           : blk_ff[BLK_W-1:1];
   assign span  = {rad, 1'b0};
   assign x_e   = (DIM_W+1)'(x_ff);
   assign y_e   = (DIM_W+1)'(y_ff);
   assign r_e   = (DIM_W+1)'(rad);

   assign sts.border = (x_e < r_e) || (x_e + r_e >= (DIM_W+1)'(w_eff)) ||
                       (y_e < r_e) || (y_e + r_e >= (DIM_W+1)'(h_eff));

   assign win_last     = (dx_ff == span) && (dy_ff == span);
   assign sts.gen_last = win_last && (cen_ff == x_ff);

   assign rd_row   = y_ff + ROW_W'(dy_ff) - ROW_W'(rad);
   assign rd_col_l = x_ff + COL_W'(dx_ff) - COL_W'(rad);
   assign rd_col_r = cen_ff + COL_W'(dx_ff) - COL_W'(rad);

   assign ad   = (rd_l_ff > rd_r_ff) ? (rd_l_ff - rd_r_ff) : (rd_r_ff - rd_l_ff);
   assign cand = sum_ff + SUM_W'(ad);

   assign disp_w    = DISP_W'(x_ff - pos_ff);
   assign eval_stat = (best_ff > thr_ff) ? STAT_NOMATCH :
                      (disp_w == '0)     ? STAT_ZERO : STAT_VALID;
   assign sts.eval_valid = (eval_stat == STAT_VALID);

   assign trial        = {rem_ff, q_ff[DEPTH_W-1]};
   assign tdiff        = trial - {1'b0, disp_ff};
   assign ge           = (trial >= {1'b0, disp_ff});
   assign sts.div_last = (cnt_ff == DIV_CNT_W'(DEPTH_W - 1));
   assign sts.out_free = !rsp_valid || rsp_ready;

   // Frame stores: one write and one registered read per store per cycle.
   always_ff @(posedge clock) begin
      if (cmd.load_wr) begin
         left_mem[{req_row, req_col}]  <= req_left_pixel;
         right_mem[{req_row, req_col}] <= req_right_pixel;
      end
      rd_l_ff <= left_mem[{rd_row, rd_col_l}];
      rd_r_ff <= right_mem[{rd_row, rd_col_r}];
   end

   // Register file.
   always_ff @(posedge clock) begin
      if (reset) begin
         fw_ff    <= DIM_W'(512);
         fh_ff    <= DIM_W'(512);
         blk_ff   <= BLK_W'(5);
         thr_ff   <= '1;
         scale_ff <= DEPTH_W'(65536);
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_FRAME_WIDTH:  fw_ff    <= csr_data[DIM_W-1:0];
            REG_FRAME_HEIGHT: fh_ff    <= csr_data[DIM_W-1:0];
            REG_BLOCK_SIZE:   blk_ff   <= csr_data[BLK_W-1:0];
            REG_THRESHOLD:    thr_ff   <= csr_data[SUM_W-1:0];
            REG_DEPTH_SCALE:  scale_ff <= csr_data[DEPTH_W-1:0];
            default: ;
         endcase
      end
   end

   // Scan walk, accumulation, evaluation and divide.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff    <= 1'b0;
         last1_ff <= 1'b0;
      end else begin
         v1_ff    <= cmd.scan_en;
         last1_ff <= cmd.scan_en && win_last;
      end
      cen1_ff <= cen_ff;
      if (cmd.latch) begin
         x_ff <= req_col;
         y_ff <= req_row;
      end
      if (cmd.check) begin
         dx_ff    <= '0;
         dy_ff    <= '0;
         cen_ff   <= COL_W'(rad);
         sum_ff   <= '0;
         first_ff <= 1'b1;
         best_ff  <= '0;
         disp_ff  <= '0;
         q_ff     <= '0;
         stat_ff  <= STAT_BORDER;
      end
      if (cmd.scan_en) begin
         if (dx_ff != span) begin
            dx_ff <= dx_ff + BLK_W'(1);
         end else begin
            dx_ff <= '0;
            if (dy_ff != span) begin
               dy_ff <= dy_ff + BLK_W'(1);
            end else begin
               dy_ff  <= '0;
               cen_ff <= cen_ff + COL_W'(1);
            end
         end
      end
      if (v1_ff) begin
         if (last1_ff) begin
            sum_ff <= '0;
            if (first_ff || (cand < best_ff)) begin
               best_ff  <= cand;
               pos_ff   <= cen1_ff;
               first_ff <= 1'b0;
            end
         end else begin
            sum_ff <= cand;
         end
      end
      if (cmd.eval) begin
         disp_ff <= disp_w;
         stat_ff <= eval_stat;
         q_ff    <= (eval_stat == STAT_VALID) ? scale_ff : '0;
         rem_ff  <= '0;
         cnt_ff  <= '0;
      end
      if (cmd.div_en) begin
         rem_ff <= ge ? tdiff[DISP_W-1:0] : trial[DISP_W-1:0];
         q_ff   <= {q_ff[DEPTH_W-2:0], ge};
         cnt_ff <= cnt_ff + DIV_CNT_W'(1);
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else if (cmd.publish) begin
         rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid <= 1'b0;
      end
      if (cmd.publish) begin
         rsp_depth     <= q_ff;
         rsp_disparity <= disp_ff;
         rsp_best_sum  <= best_ff;
         rsp_status    <= stat_ff;
      end
   end

endmodule

// ===== src/stereo_sad_depth_search.sv =====
// Top level of the stereo SAD depth search block.
// A load item writes one left and one right pixel into two 512 x 512 frame
// stores. A query item on a border pixel returns status border without a
// scan. Any other query walks every right-frame center c from radius r to
// the query column, reading one pixel pair per cycle from the single read
// port of each frame store for each (2r+1) x (2r+1) window, followed by a
// bit-per-cycle division when a depth is produced. Results leave through an
// output register, so the next item is taken while a result waits. Store
// contents are undefined until loaded; configuration is taken at any time
// and must be written while the block is idle.
module stereo_sad_depth_search import ssd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   ssd_req_if.sink    req_chan,
   ssd_rsp_if.source  rsp_chan,
   ssd_csr_if.sink    csr_chan
);

   ssd_cmd_type cmd;
   ssd_sts_type sts;

   // Register writes never stall.
   assign csr_chan.ready = 1'b1;

   // Sequencer: accepts items, steps the datapath through each query.
   ssd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_chan.valid),
      .req_opcode (req_chan.opcode),
      .req_ready  (req_chan.ready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // Datapath: frame stores, SAD search, divider, result register.
   ssd_datapath u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_col         (req_chan.col),
      .req_row         (req_chan.row),
      .req_left_pixel  (req_chan.left_pixel),
      .req_right_pixel (req_chan.right_pixel),
      .csr_valid       (csr_chan.valid),
      .csr_index       (csr_chan.index),
      .csr_data        (csr_chan.data),
      .rsp_valid       (rsp_chan.valid),
      .rsp_ready       (rsp_chan.ready),
      .rsp_depth       (rsp_chan.depth),
      .rsp_disparity   (rsp_chan.disparity),
      .rsp_best_sum    (rsp_chan.best_sum),
      .rsp_status      (rsp_chan.status)
   );

endmodule

// ===== src/ssd_checker.sv =====
// Port-level checks on the result channel, bound to the top level.
module ssd_checker import ssd_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [DEPTH_W-1:0] rsp_depth,
   input logic [DISP_W-1:0]  rsp_disparity,
   input logic [SUM_W-1:0]   rsp_best_sum,
   input logic [1:0]         rsp_status
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_depth))
      else $error("result dropped or changed while stalled");

   a_border_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STAT_BORDER |->
         rsp_depth == '0 && rsp_disparity == '0 && rsp_best_sum == '0)
      else $error("border result carries nonzero fields");

   a_depth_only_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STAT_VALID |-> rsp_depth == '0)
      else $error("depth nonzero on non-valid status");

   a_disp_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STAT_VALID || rsp_status == STAT_ZERO) |->
         ((rsp_status == STAT_ZERO) == (rsp_disparity == '0)))
      else $error("disparity does not match status");

endmodule

bind stereo_sad_depth_search ssd_checker u_ssd_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_depth     (rsp_chan.depth),
   .rsp_disparity (rsp_chan.disparity),
   .rsp_best_sum  (rsp_chan.best_sum),
   .rsp_status    (rsp_chan.status)
);
